// ===== rtl/mfgp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfgp_pkg
// Shared types, geometry constants and the 4x5 font for the glyph plotter.
// ----------------------------------------------------------------------------
package mfgp_pkg;

    // panel geometry, folded layout
    localparam int FOLDED_ROWS   = 32;
    localparam int WORDS_PER_ROW = 16;
    localparam int STORE_DEPTH   = FOLDED_ROWS * WORDS_PER_ROW;
    localparam int SCREEN_W      = 8 * WORDS_PER_ROW;
    localparam int SCREEN_H      = 2 * FOLDED_ROWS;
    localparam int ADDR_W        = $clog2(STORE_DEPTH);

    localparam int GLYPH_COUNT   = 13;
    localparam int GLYPH_ROWS    = 5;
    localparam int GLYPH_W_MAX   = 5;

    localparam int QUEUE_DEPTH   = 4;

    // five row nibbles per glyph, top row in the high nibble
    localparam logic [19:0] FONT [GLYPH_COUNT] = '{
        20'h69996, 20'h26227, 20'h6924F, 20'h69296, 20'h26AF2,
        20'hE8E1E, 20'h68E96, 20'hF1244, 20'h69696, 20'h69716,
        20'h00001, 20'h01010, 20'h00000
    };
    localparam logic [2:0] FONT_W [GLYPH_COUNT] = '{
        3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5,
        3'd2, 3'd2, 3'd5
    };

    typedef enum logic [1:0] {
        ACT_PLOT  = 2'd0,
        ACT_GLYPH = 2'd1,
        ACT_CLEAR = 2'd2,
        ACT_READ  = 2'd3
    } t_action;

    typedef struct packed {
        t_action    action;
        logic [6:0] pos_x;
        logic [5:0] pos_y;
        logic       pixel_on;
        logic [3:0] glyph_code;
        logic [4:0] read_row;
        logic [3:0] read_column;
    } t_in;

    typedef struct packed {
        logic [15:0] rd_word;
        logic [7:0]  next_x;
        logic        bad_glyph;
    } t_out;

    // work for the back end
    typedef enum logic [1:0] {
        K_WRITE = 2'd0,
        K_READ  = 2'd1,
        K_CLEAR = 2'd2,
        K_NOTE  = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic [ADDR_W-1:0] addr;
        logic [15:0]       mask;
        logic              set;
        logic              last;
        logic [7:0]        next_x;
        logic              bad;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    function automatic logic glyph_ok(input logic [3:0] code);
        return 5'(code) < 5'(GLYPH_COUNT);
    endfunction

    function automatic logic [2:0] glyph_width(input logic [3:0] code);
        return glyph_ok(code) ? FONT_W[code] : 3'd0;
    endfunction

    function automatic logic [3:0] font_row(input logic [3:0] code, input logic [2:0] row);
        logic [19:0] g;
        g = glyph_ok(code) ? FONT[code] : 20'h00000;
        case (row)
            3'd0:    return g[19:16];
            3'd1:    return g[15:12];
            3'd2:    return g[11:8];
            3'd3:    return g[7:4];
            default: return g[3:0];
        endcase
    endfunction

endpackage

// ===== rtl/mfgp_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfgp_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module mfgp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/mfgp_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfgp_fifo
// Short command queue between the front end and the back end.
// ----------------------------------------------------------------------------
module mfgp_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  mfgp_pkg::t_cmd  i_cmd,
    input  logic            i_pop,
    output mfgp_pkg::t_cmd  o_head,
    output mfgp_pkg::t_qstat o_qstat
);
    import mfgp_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wptr, n_wptr;
    logic [PTR_W-1:0] r_rptr, n_rptr;
    logic [CNT_W-1:0] r_count, n_count;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_comb begin
        n_wptr  = i_push ? bump(r_wptr) : r_wptr;
        n_rptr  = i_pop  ? bump(r_rptr) : r_rptr;
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    assign o_head        = r_mem[r_rptr];
    assign o_qstat.full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_qstat.empty = (r_count == '0);

endmodule

// ===== rtl/mfgp_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfgp_front
// Accepts beats, classifies them and expands glyphs into word commands.
// ----------------------------------------------------------------------------
module mfgp_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  mfgp_pkg::t_in    i_in,
    input  logic             i_ready,
    input  mfgp_pkg::t_qstat i_qstat,
    output logic             o_push,
    output mfgp_pkg::t_cmd   o_cmd
);
    import mfgp_pkg::*;

    typedef enum logic [1:0] {
        F_IDLE  = 2'b01,
        F_GLYPH = 2'b10
    } t_fstate;

    t_fstate    r_state, n_state;
    logic [6:0] r_gx, n_gx;
    logic [5:0] r_gy, n_gy;
    logic [3:0] r_code, n_code;
    logic [2:0] r_row, n_row;
    logic       r_half, n_half;

    logic        accept;
    logic        step_last;
    logic [4:0]  left5;
    logic [31:0] window;
    logic [7:0]  w_col;
    logic [7:0]  w_y;
    logic [15:0] w_raw;
    logic [15:0] w_mask;
    logic        w_fold;
    logic [7:0]  w_frow;
    logic [7:0]  w_wcol;
    logic [15:0] w_idx;
    logic        loc_ok;
    logic [15:0] rd_idx;
    logic        rd_ok;

    assign o_in_stall = (r_state != F_IDLE) || i_qstat.full || !i_ready;
    assign accept     = i_in_valid && !o_in_stall;
    assign step_last  = (r_row == 3'(GLYPH_ROWS - 1)) && r_half;

    // glyph row left-aligned in a five-pixel span, then placed over two words
    assign left5  = 5'(font_row(r_code, r_row)) << 3'(GLYPH_W_MAX - 32'(glyph_width(r_code)));
    assign window = {left5, 27'd0} >> r_gx[3:0];

    always_comb begin
        if (r_state == F_GLYPH) begin
            w_col = 8'(r_gx[6:4]) + 8'(r_half);
            w_y   = 8'(r_gy) + 8'(r_row);
            w_raw = r_half ? window[15:0] : window[31:16];
        end else begin
            w_col = 8'(i_in.pos_x[6:4]);
            w_y   = 8'(i_in.pos_y);
            w_raw = 16'h8000 >> i_in.pos_x[3:0];
        end
        // drop pixels past the right edge
        for (int b = 0; b < 16; b++) begin
            w_mask[b] = w_raw[b] && (({w_col, 4'd0} + 12'(15 - b)) < 12'(SCREEN_W));
        end
        w_fold = w_y >= 8'(FOLDED_ROWS);
        w_frow = w_fold ? w_y - 8'(FOLDED_ROWS) : w_y;
        w_wcol = w_fold ? w_col + 8'(WORDS_PER_ROW / 2) : w_col;
        w_idx  = 16'(w_frow) * 16'(WORDS_PER_ROW) + 16'(w_wcol);
        loc_ok = (w_y < 8'(SCREEN_H)) && (w_idx < 16'(STORE_DEPTH)) && (|w_mask);
    end

    assign rd_idx = 16'(i_in.read_row) * 16'(WORDS_PER_ROW) + 16'(i_in.read_column);
    assign rd_ok  = (16'(i_in.read_row) < 16'(FOLDED_ROWS))
                 && (16'(i_in.read_column) < 16'(WORDS_PER_ROW));

    always_comb begin
        o_cmd.kind   = loc_ok ? K_WRITE : K_NOTE;
        o_cmd.addr   = w_idx[ADDR_W-1:0];
        o_cmd.mask   = w_mask;
        o_cmd.set    = 1'b1;
        o_cmd.last   = 1'b1;
        o_cmd.next_x = 8'(i_in.pos_x);
        o_cmd.bad    = 1'b0;
        o_push       = 1'b0;
        n_state      = r_state;
        n_gx         = r_gx;
        n_gy         = r_gy;
        n_code       = r_code;
        n_row        = r_row;
        n_half       = r_half;
        case (r_state)
            F_IDLE: begin
                case (i_in.action)
                    ACT_PLOT: begin
                        o_cmd.set = i_in.pixel_on;
                        o_push    = accept;
                    end
                    ACT_GLYPH: begin
                        o_cmd.kind = K_NOTE;
                        o_cmd.bad  = 1'b1;
                        if (accept) begin
                            if (glyph_ok(i_in.glyph_code)) begin
                                n_state = F_GLYPH;
                                n_gx    = i_in.pos_x;
                                n_gy    = i_in.pos_y;
                                n_code  = i_in.glyph_code;
                                n_row   = '0;
                                n_half  = 1'b0;
                            end else begin
                                o_push = 1'b1;
                            end
                        end
                    end
                    ACT_CLEAR: begin
                        o_cmd.kind = K_CLEAR;
                        o_push     = accept;
                    end
                    default: begin
                        o_cmd.kind = rd_ok ? K_READ : K_NOTE;
                        o_cmd.addr = rd_idx[ADDR_W-1:0];
                        o_push     = accept;
                    end
                endcase
            end
            F_GLYPH: begin
                o_cmd.last   = step_last;
                o_cmd.next_x = 8'(r_gx) + 8'(glyph_width(r_code));
                if (!i_qstat.full) begin
                    // words with nothing to draw are skipped, the final step always goes
                    o_push = loc_ok || step_last;
                    if (step_last) begin
                        n_state = F_IDLE;
                    end else if (r_half) begin
                        n_half = 1'b0;
                        n_row  = r_row + 3'd1;
                    end else begin
                        n_half = 1'b1;
                    end
                end
            end
            default: begin
                n_state = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_row   <= '0;
            r_half  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_row   <= n_row;
            r_half  <= n_half;
        end
    end

    always_ff @(posedge i_clk) begin
        r_gx   <= n_gx;
        r_gy   <= n_gy;
        r_code <= n_code;
    end

endmodule

// ===== rtl/mfgp_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfgp_back
// Runs queued commands against the frame store and registers the results.
// ----------------------------------------------------------------------------
module mfgp_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  mfgp_pkg::t_cmd   i_head,
    input  mfgp_pkg::t_qstat i_qstat,
    output logic             o_pop,
    output logic             o_ready,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output mfgp_pkg::t_out   o_out
);
    import mfgp_pkg::*;

    typedef enum logic [4:0] {
        B_CLEAR  = 5'b00001,
        B_IDLE   = 5'b00010,
        B_MODIFY = 5'b00100,
        B_FETCH  = 5'b01000,
        B_RESULT = 5'b10000
    } t_bstate;

    t_bstate           r_state, n_state;
    logic [ADDR_W-1:0] r_clr_addr, n_clr_addr;
    logic              r_clr_report, n_clr_report;
    logic              r_init_done, n_init_done;
    logic              r_out_valid, n_out_valid;
    t_cmd              r_cmd, n_cmd;
    logic [15:0]       r_data, n_data;
    t_out              r_out, n_out;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [15:0]       ram_wdata;
    logic              ram_re;
    logic [15:0]       ram_rdata;
    logic              out_free;

    mfgp_ram #(
        .WIDTH (16),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (i_head.addr),
        .o_rdata (ram_rdata)
    );

    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state      = r_state;
        n_clr_addr   = r_clr_addr;
        n_clr_report = r_clr_report;
        n_init_done  = r_init_done;
        n_out_valid  = r_out_valid && i_out_stall;
        n_cmd        = r_cmd;
        n_data       = r_data;
        n_out        = r_out;
        o_pop        = 1'b0;
        ram_we       = 1'b0;
        ram_waddr    = r_cmd.addr;
        ram_wdata    = '0;
        ram_re       = 1'b0;
        case (r_state)
            B_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr_addr;
                if (r_clr_addr == ADDR_W'(STORE_DEPTH - 1)) begin
                    n_clr_addr  = '0;
                    n_init_done = 1'b1;
                    n_state     = r_clr_report ? B_RESULT : B_IDLE;
                end else begin
                    n_clr_addr = r_clr_addr + ADDR_W'(1);
                end
            end
            B_IDLE: begin
                if (!i_qstat.empty) begin
                    o_pop  = 1'b1;
                    n_cmd  = i_head;
                    n_data = '0;
                    case (i_head.kind)
                        K_WRITE: begin
                            ram_re  = 1'b1;
                            n_state = B_MODIFY;
                        end
                        K_READ: begin
                            ram_re  = 1'b1;
                            n_state = B_FETCH;
                        end
                        K_CLEAR: begin
                            n_clr_report = 1'b1;
                            n_state      = B_CLEAR;
                        end
                        default: begin
                            n_state = B_RESULT;
                        end
                    endcase
                end
            end
            B_MODIFY: begin
                ram_we    = 1'b1;
                ram_wdata = r_cmd.set ? (ram_rdata | r_cmd.mask) : (ram_rdata & ~r_cmd.mask);
                n_state   = r_cmd.last ? B_RESULT : B_IDLE;
            end
            B_FETCH: begin
                n_data  = ram_rdata;
                n_state = B_RESULT;
            end
            B_RESULT: begin
                if (out_free) begin
                    n_out_valid     = 1'b1;
                    n_out.rd_word   = r_data;
                    n_out.next_x    = r_cmd.next_x;
                    n_out.bad_glyph = r_cmd.bad;
                    n_clr_report    = 1'b0;
                    n_state         = B_IDLE;
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= B_CLEAR;
            r_clr_addr   <= '0;
            r_clr_report <= 1'b0;
            r_init_done  <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_clr_addr   <= n_clr_addr;
            r_clr_report <= n_clr_report;
            r_init_done  <= n_init_done;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd  <= n_cmd;
        r_data <= n_data;
        r_out  <= n_out;
    end

    assign o_ready     = r_init_done;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// ===== rtl/mono_framebuffer_glyph_plotter_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mono_framebuffer_glyph_plotter_top
// 128x64 monochrome frame store in the folded 32x16-word layout, with pixel
// plot, 4x5 glyph blit, full clear and word read.
// ----------------------------------------------------------------------------
// the back end runs one queued command at a time; a clear sweeps the whole store
//   before its result, and a glyph touches up to ten words
// throughput: the 4-entry queue takes short bursts at one per cycle while it has
//   room, and a glyph holds the front for ten steps
// reset: after i_rst_n the store is swept to zero with o_in_stall high
// ----------------------------------------------------------------------------
module mono_framebuffer_glyph_plotter_top (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  mfgp_pkg::t_in  i_in,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output mfgp_pkg::t_out o_out
);
    import mfgp_pkg::*;

    // front to queue
    logic   push;
    t_cmd   push_cmd;
    // queue to back
    logic   pop;
    t_cmd   head;
    t_qstat qstat;
    // back end finished its start-up sweep
    logic   ready;

    // classify each beat; glyphs become one command per touched word, the final step always goes
    mfgp_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in       (i_in),
        .i_ready    (ready),
        .i_qstat    (qstat),
        .o_push     (push),
        .o_cmd      (push_cmd)
    );

    // decouples the expansion steps from the memory port
    mfgp_fifo u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_head  (head),
        .o_qstat (qstat)
    );

    // owns the frame store and the output register
    mfgp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .i_qstat     (qstat),
        .o_pop       (pop),
        .o_ready     (ready),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

endmodule

// ===== sim/tb_mono_framebuffer_glyph_plotter_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mono_framebuffer_glyph_plotter_top
// Drives plot, glyph, clear and read commands into the glyph plotter with
// bursty input and a patterned output stall. A shadow frame store predicts
// every result, and each result beat is checked field by field.
// ----------------------------------------------------------------------------
module tb_mono_framebuffer_glyph_plotter_top;
    import mfgp_pkg::*;

    localparam int RANDOM_BEATS = 900;
    localparam int IDLE_LIMIT   = 20000;
    localparam int DRAIN_CYCLES = 30;

    // 4x5 font, top row in the high nibble, and the advance of each glyph
    localparam logic [19:0] DOT_ROWS [13] = '{
        20'h69996, 20'h26227, 20'h6924F, 20'h69296, 20'h26AF2,
        20'hE8E1E, 20'h68E96, 20'hF1244, 20'h69696, 20'h69716,
        20'h00001, 20'h01010, 20'h00000
    };
    localparam int ADVANCE [13] = '{5, 5, 5, 5, 5, 5, 5, 5, 5, 5, 2, 2, 5};

    // shadow frame store plus the results it predicts
    class frame_shadow;
        logic [15:0] words [STORE_DEPTH];
        t_out        due_results [$];
        int          errors;

        function new();
            wipe();
            errors = 0;
        endfunction

        function void wipe();
            foreach (words[i]) words[i] = 16'h0000;
        endfunction

        function void paint(int x, int y, bit on);
            int          row;
            int          col;
            logic [15:0] bit_mask;
            if (x >= SCREEN_W || y >= SCREEN_H) return;
            row = y % FOLDED_ROWS;
            col = x / 16 + ((y >= FOLDED_ROWS) ? WORDS_PER_ROW / 2 : 0);
            bit_mask = 16'h8000 >> (x % 16);
            if (on) words[row * WORDS_PER_ROW + col] |= bit_mask;
            else    words[row * WORDS_PER_ROW + col] &= ~bit_mask;
        endfunction

        function void predict_command(t_in cmd);
            t_out want;
            int   w;
            int   bits;
            want.rd_word   = 16'h0000;
            want.next_x    = {1'b0, cmd.pos_x};
            want.bad_glyph = 1'b0;
            case (cmd.action)
                ACT_PLOT: begin
                    paint(cmd.pos_x, cmd.pos_y, cmd.pixel_on);
                end
                ACT_GLYPH: begin
                    if (cmd.glyph_code >= GLYPH_COUNT) begin
                        want.bad_glyph = 1'b1;
                    end else begin
                        w = ADVANCE[cmd.glyph_code];
                        for (int r = 0; r < 5; r++) begin
                            bits = DOT_ROWS[cmd.glyph_code][19 - 4 * r -: 4];
                            for (int c = 0; c < w; c++) begin
                                if ((bits >> (w - 1 - c)) & 1)
                                    paint(cmd.pos_x + c, cmd.pos_y + r, 1'b1);
                            end
                        end
                        want.next_x = 8'(cmd.pos_x + w);
                    end
                end
                ACT_CLEAR: begin
                    wipe();
                end
                default: begin
                    if (cmd.read_row < FOLDED_ROWS && cmd.read_column < WORDS_PER_ROW)
                        want.rd_word = words[cmd.read_row * WORDS_PER_ROW
                                             + cmd.read_column];
                end
            endcase
            due_results.push_back(want);
        endfunction

        function void report(string what, int want, int got);
            errors++;
            if (errors <= 10)
                $display("mismatch %0t: %s expected %h got %h", $time, what, want, got);
        endfunction

        function void check_result(t_out got);
            t_out want;
            if (due_results.size() == 0) begin
                report("unexpected result beat", 0, got);
                return;
            end
            want = due_results.pop_front();
            if (got.rd_word !== want.rd_word)
                report("rd_word", want.rd_word, got.rd_word);
            if (got.next_x !== want.next_x)
                report("next_x", want.next_x, got.next_x);
            if (got.bad_glyph !== want.bad_glyph)
                report("bad_glyph", want.bad_glyph, got.bad_glyph);
        endfunction

        function int pending();
            return due_results.size();
        endfunction
    endclass

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_in_valid  = 1'b0;
    logic i_out_stall = 1'b0;
    t_in  i_in        = '0;
    logic o_in_stall;
    logic o_out_valid;
    t_out o_out;

    frame_shadow shadow = new();
    int          idle_cycles = 0;
    int          in_beats    = 0;
    int          last_x      = 0;
    int          last_y      = 0;

    mono_framebuffer_glyph_plotter_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // beat monitor: feeds the shadow store, checks result beats and counts idle cycles
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            shadow.predict_command(i_in);
            in_beats <= in_beats + 1;
        end
        if (i_rst_n && o_out_valid && !i_out_stall)
            shadow.check_result(o_out);
        if (i_rst_n && ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin : watchdog
        wait (idle_cycles >= IDLE_LIMIT);
        $display("tb_mono_framebuffer_glyph_plotter_top: done, errors");
        $finish;
    end

    // output side: stall pattern in segments, one long hold-off mid run
    initial begin : result_sink
        int  mode;
        int  len;
        bit  held;
        held = 1'b0;
        forever begin
            mode = $urandom_range(0, 3);
            len  = $urandom_range(1, 60);
            if (!held && in_beats >= 400) begin
                mode = 4;
                len  = 400;
                held = 1'b1;
            end
            for (int k = 0; k < len; k++) begin
                @(posedge i_clk);
                case (mode)
                    0:       i_out_stall <= 1'b0;
                    1:       i_out_stall <= ($urandom_range(0, 3) == 0);
                    2:       i_out_stall <= $urandom_range(0, 1);
                    3:       i_out_stall <= ($urandom_range(0, 3) != 0);
                    default: i_out_stall <= 1'b1;
                endcase
            end
        end
    end

    task automatic send_beat(input t_in cmd);
        i_in       <= cmd;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (shadow.pending() != 0) @(posedge i_clk);
    endtask

    function automatic t_in noise_fields(t_action act);
        t_in cmd;
        cmd.action      = act;
        cmd.pos_x       = 7'($urandom);
        cmd.pos_y       = 6'($urandom);
        cmd.pixel_on    = 1'($urandom);
        cmd.glyph_code  = 4'($urandom);
        cmd.read_row    = 5'($urandom);
        cmd.read_column = 4'($urandom);
        return cmd;
    endfunction

    function automatic t_in plot_cmd(int x, int y, bit on);
        t_in cmd;
        cmd          = noise_fields(ACT_PLOT);
        cmd.pos_x    = 7'(x);
        cmd.pos_y    = 6'(y);
        cmd.pixel_on = on;
        return cmd;
    endfunction

    function automatic t_in read_cmd(int row, int col);
        t_in cmd;
        cmd             = noise_fields(ACT_READ);
        cmd.read_row    = 5'(row);
        cmd.read_column = 4'(col);
        return cmd;
    endfunction

    // random command; reads lean toward the last drawn spot
    function automatic t_in random_cmd();
        t_in cmd;
        int  pick;
        int  px;
        int  py;
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
            cmd = noise_fields(ACT_PLOT);
        end else if (pick < 65) begin
            cmd = noise_fields(ACT_GLYPH);
            if ($urandom_range(0, 4) != 0) cmd.glyph_code = 4'($urandom_range(0, 12));
            if ($urandom_range(0, 7) == 0) cmd.pos_x = 7'($urandom_range(120, 127));
            if ($urandom_range(0, 7) == 0) cmd.pos_y = 6'($urandom_range(58, 63));
        end else if (pick < 97) begin
            cmd = noise_fields(ACT_READ);
            if ($urandom_range(0, 1) == 0) begin
                px = last_x + $urandom_range(0, 4);
                py = last_y + $urandom_range(0, 4);
                if (px > 127) px = 127;
                if (py > 63) py = 63;
                cmd.read_row    = 5'(py % FOLDED_ROWS);
                cmd.read_column = 4'(px / 16 + ((py >= FOLDED_ROWS) ? 8 : 0));
            end
        end else begin
            cmd = noise_fields(ACT_CLEAR);
        end
        if (cmd.action == ACT_PLOT || cmd.action == ACT_GLYPH) begin
            last_x = cmd.pos_x;
            last_y = cmd.pos_y;
        end
        return cmd;
    endfunction

    initial begin : stimulus
        t_in cmd;
        int  burst;
        int  gap;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // corners, set then clear, read extremes
        send_beat(noise_fields(ACT_CLEAR));
        send_beat(plot_cmd(0, 0, 1'b1));
        send_beat(plot_cmd(127, 63, 1'b1));
        send_beat(read_cmd(0, 0));
        send_beat(read_cmd(31, 15));
        send_beat(plot_cmd(127, 63, 1'b0));
        send_beat(read_cmd(31, 15));
        // every code, straddling word and fold edges; clipping at the corner
        for (int code = 0; code < 16; code++) begin
            cmd            = noise_fields(ACT_GLYPH);
            cmd.glyph_code = 4'(code);
            cmd.pos_x      = 7'(8 * code + 3);
            cmd.pos_y      = 6'd30;
            if (code == 9) begin
                cmd.pos_x = 7'd124;
                cmd.pos_y = 6'd60;
            end
            if (code == 11) begin
                cmd.pos_x = 7'd127;
                cmd.pos_y = 6'd63;
            end
            send_beat(cmd);
        end
        send_beat(read_cmd(31, 0));
        send_beat(read_cmd(28, 15));
        wait_drained();

        burst = 0;
        for (int k = 0; k < RANDOM_BEATS; k++) begin
            if (k == RANDOM_BEATS / 2) begin
                wait_drained();
                burst = $urandom_range(1, 40);
            end else if (burst == 0) begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                if (gap != 0) begin
                    i_in_valid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
                burst = $urandom_range(1, 40);
            end
            send_beat(random_cmd());
            burst--;
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (shadow.errors == 0 && shadow.pending() == 0)
            $display("tb_mono_framebuffer_glyph_plotter_top: done, clean");
        else
            $display("tb_mono_framebuffer_glyph_plotter_top: done, errors");
        $finish;
    end

endmodule

// ===== mono_framebuffer_glyph_plotter_top.f =====
rtl/mfgp_pkg.sv
rtl/mfgp_ram.sv
rtl/mfgp_fifo.sv
rtl/mfgp_front.sv
rtl/mfgp_back.sv
rtl/mono_framebuffer_glyph_plotter_top.sv
sim/tb_mono_framebuffer_glyph_plotter_top.sv
